@@ rtl/image_3x3_neighbourhood_filter_top_assert.svh @@
// assertion macros for the 3x3 neighbourhood filter
// used by image_3x3_neighbourhood_filter_top only, needs nothing else
`ifndef IMAGE_3X3_NEIGHBOURHOOD_FILTER_TOP_ASSERT_SVH
`define IMAGE_3X3_NEIGHBOURHOOD_FILTER_TOP_ASSERT_SVH

// condition in the same cycle
`define NBF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// condition in the following cycle
`define NBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/nbf_pkg.sv @@
// shared constants, types and tables of the 3x3 neighbourhood filter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nbf_pkg;

    localparam int unsigned IMAGE_WIDTH_MAX  = 1024;
    localparam int unsigned IMAGE_HEIGHT_MAX = 4096;

    localparam int unsigned PIX_W    = 8;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned WIDTH_W  = 11;
    localparam int unsigned HEIGHT_W = 13;
    localparam int unsigned COL_W    = $clog2(IMAGE_WIDTH_MAX);
    localparam int unsigned ROW_W    = $clog2(IMAGE_HEIGHT_MAX);
    localparam int unsigned LINE_W   = 2 * PIX_W;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [MODE_W-1:0] MODE_BLUR    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LAPLACE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SHARPEN = 2'd2;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam int unsigned FIFO_DEPTH = 8;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int unsigned SUM_W       = 12;
    localparam int unsigned CNT_W       = 4;
    localparam int unsigned LIN_W       = 12;
    localparam int unsigned RECIP_SHIFT = 16;
    localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;

    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
        logic last;
    } t_meta;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             last;
    } t_result;

    // ceil(2^16 / n): exact floor division for sums up to 9*255
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        unique case (n)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            4'd9:    r = 17'd7282;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/nbf_pix_if.sv @@
// input pixel channel: valid/ready with command and grey level
// depends on nbf_pkg
`timescale 1ns / 1ps
`default_nettype none

interface nbf_pix_if;
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic [nbf_pkg::PIX_W-1:0] pixel_value;

    modport source (output valid, command, pixel_value, input ready);
    modport sink   (input valid, command, pixel_value, output ready);
endinterface

`default_nettype wire

@@ rtl/nbf_res_if.sv @@
// result channel: valid/ready with filtered value and end of frame flag
// depends on nbf_pkg
`timescale 1ns / 1ps
`default_nettype none

interface nbf_res_if;
    logic                      valid;
    logic                      ready;
    logic [nbf_pkg::PIX_W-1:0] filtered_value;
    logic                      last_of_frame;

    modport source (output valid, filtered_value, last_of_frame, input ready);
    modport sink   (input valid, filtered_value, last_of_frame, output ready);
endinterface

`default_nettype wire

@@ rtl/nbf_line_buf.sv @@
// two line stores packed into one memory word {two rows up, one row up}
// read at transfer, written back in the next cycle; depends on nbf_pkg
`timescale 1ns / 1ps
`default_nettype none

module nbf_line_buf (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_rd_en,
    input  wire logic [nbf_pkg::COL_W-1:0] i_col,
    input  wire logic [nbf_pkg::PIX_W-1:0] i_pix,
    output logic      [nbf_pkg::PIX_W-1:0] o_col_top,
    output logic      [nbf_pkg::PIX_W-1:0] o_col_mid,
    output logic      [nbf_pkg::PIX_W-1:0] o_col_bot
);

    logic [nbf_pkg::LINE_W-1:0] r_mem [nbf_pkg::IMAGE_WIDTH_MAX];
    logic [nbf_pkg::LINE_W-1:0] r_rd;
    logic [nbf_pkg::LINE_W-1:0] r_fwd_data;
    logic                       r_fwd;
    logic                       r_wr_v;
    logic [nbf_pkg::COL_W-1:0]  r_col;
    logic [nbf_pkg::PIX_W-1:0]  r_pix;
    logic [nbf_pkg::LINE_W-1:0] w_word;
    logic [nbf_pkg::LINE_W-1:0] w_wr_data;

    // same column read while its write-back is in flight (one pixel wide rows)
    assign w_word    = r_fwd ? r_fwd_data : r_rd;
    assign o_col_top = w_word[nbf_pkg::LINE_W-1:nbf_pkg::PIX_W];
    assign o_col_mid = w_word[nbf_pkg::PIX_W-1:0];
    assign o_col_bot = r_pix;
    assign w_wr_data = {o_col_mid, r_pix};

    always_ff @(posedge i_clk) begin
        if (r_wr_v) begin
            r_mem[r_col] <= w_wr_data;
        end
        if (i_rd_en) begin
            r_rd       <= r_mem[i_col];
            r_col      <= i_col;
            r_pix      <= i_pix;
            r_fwd_data <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_v <= 1'b0;
            r_fwd  <= 1'b0;
        end else begin
            r_wr_v <= i_rd_en;
            r_fwd  <= i_rd_en && r_wr_v && (i_col == r_col);
        end
    end

endmodule

`default_nettype wire

@@ rtl/nbf_window.sv @@
// 3x3 window registers and the kernel: masked sums, then divide or clamp
// depends on nbf_pkg
`timescale 1ns / 1ps
`default_nettype none

module nbf_window (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_shift,
    input  wire logic                       i_emit,
    input  wire nbf_pkg::t_meta             i_meta,
    input  wire logic [nbf_pkg::MODE_W-1:0] i_mode,
    input  wire logic [nbf_pkg::PIX_W-1:0]  i_col_top,
    input  wire logic [nbf_pkg::PIX_W-1:0]  i_col_mid,
    input  wire logic [nbf_pkg::PIX_W-1:0]  i_col_bot,
    output logic                            o_valid,
    output nbf_pkg::t_result                o_result,
    output logic [1:0]                      o_busy
);

    logic [nbf_pkg::PIX_W-1:0] r_win [9];
    logic                      r_v2;
    nbf_pkg::t_meta            r_meta2;

    logic                              r_v3;
    logic                              r_last3;
    logic                              r_blur3;
    logic [nbf_pkg::SUM_W-1:0]         r_sum3;
    logic [nbf_pkg::RECIP_W-1:0]       r_recip3;
    logic signed [nbf_pkg::LIN_W-1:0]  r_lin3;

    logic [8:0]                        w_ok;
    logic [2:0]                        w_row_ok;
    logic [2:0]                        w_col_ok;
    logic [nbf_pkg::SUM_W-1:0]         w_sum;
    logic [nbf_pkg::CNT_W-1:0]         w_cnt;
    logic [nbf_pkg::PIX_W+1:0]         w_nb;
    logic signed [nbf_pkg::LIN_W-1:0]  w_nb_s;
    logic signed [nbf_pkg::LIN_W-1:0]  w_ctr_s;
    logic signed [nbf_pkg::LIN_W-1:0]  w_lin;
    logic                              w_blur;
    logic [nbf_pkg::SUM_W+nbf_pkg::RECIP_W-1:0] w_prod;
    logic [nbf_pkg::PIX_W-1:0]         w_clamp;

    // window shift: left column drops out, new column enters on the right
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_shift) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]   <= r_win[r*3+1];
                r_win[r*3+1] <= r_win[r*3+2];
            end
            r_win[2] <= i_col_top;
            r_win[5] <= i_col_mid;
            r_win[8] <= i_col_bot;
        end
    end

    always_comb begin
        w_row_ok = {r_meta2.bottom, 1'b1, r_meta2.top};
        w_col_ok = {r_meta2.right, 1'b1, r_meta2.left};
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                w_ok[r*3+c] = w_row_ok[r] & w_col_ok[c];
            end
        end
    end

    always_comb begin
        w_sum = '0;
        w_cnt = '0;
        for (int i = 0; i < 9; i++) begin
            if (w_ok[i]) begin
                w_sum = w_sum + nbf_pkg::SUM_W'(r_win[i]);
                w_cnt = w_cnt + nbf_pkg::CNT_W'(1);
            end
        end
    end

    always_comb begin
        w_nb = '0;
        if (w_ok[1]) w_nb = w_nb + (nbf_pkg::PIX_W+2)'(r_win[1]);
        if (w_ok[3]) w_nb = w_nb + (nbf_pkg::PIX_W+2)'(r_win[3]);
        if (w_ok[5]) w_nb = w_nb + (nbf_pkg::PIX_W+2)'(r_win[5]);
        if (w_ok[7]) w_nb = w_nb + (nbf_pkg::PIX_W+2)'(r_win[7]);
    end

    assign w_nb_s  = $signed(nbf_pkg::LIN_W'(w_nb));
    assign w_ctr_s = $signed(nbf_pkg::LIN_W'(r_win[4]));
    assign w_blur  = (i_mode != nbf_pkg::MODE_LAPLACE) && (i_mode != nbf_pkg::MODE_SHARPEN);

    always_comb begin
        if (i_mode == nbf_pkg::MODE_LAPLACE) begin
            w_lin = w_nb_s - (w_ctr_s <<< 2);
        end else begin
            w_lin = (w_ctr_s <<< 2) + w_ctr_s - w_nb_s;
        end
    end

    always_ff @(posedge i_clk) begin
        r_meta2  <= i_meta;
        r_sum3   <= w_sum;
        r_recip3 <= nbf_pkg::recip(w_cnt);
        r_lin3   <= w_lin;
        r_blur3  <= w_blur;
        r_last3  <= r_meta2.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v2 <= i_shift & i_emit;
            r_v3 <= r_v2;
        end
    end

    // mean by reciprocal multiply, kernels clamp to the pixel range
    assign w_prod = r_sum3 * r_recip3;

    always_comb begin
        if (r_lin3 < 0) begin
            w_clamp = '0;
        end else if (r_lin3 > $signed(nbf_pkg::LIN_W'(255))) begin
            w_clamp = '1;
        end else begin
            w_clamp = r_lin3[nbf_pkg::PIX_W-1:0];
        end
    end

    assign o_valid        = r_v3;
    assign o_result.value = r_blur3 ? w_prod[nbf_pkg::RECIP_SHIFT +: nbf_pkg::PIX_W] : w_clamp;
    assign o_result.last  = r_last3;
    assign o_busy         = 2'(r_v2) + 2'(r_v3);

endmodule

`default_nettype wire

@@ rtl/nbf_out_fifo.sv @@
// result queue in front of the output channel, decouples the pipeline
// from downstream stalls; depends on nbf_pkg and nbf_res_if
`timescale 1ns / 1ps
`default_nettype none

module nbf_out_fifo (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_push,
    input  wire nbf_pkg::t_result               i_data,
    nbf_res_if.source                           o_res,
    output logic [nbf_pkg::FIFO_CNT_W-1:0]      o_count
);

    nbf_pkg::t_result                r_mem [nbf_pkg::FIFO_DEPTH];
    logic [nbf_pkg::FIFO_PTR_W-1:0]  r_wr_ptr;
    logic [nbf_pkg::FIFO_PTR_W-1:0]  r_rd_ptr;
    logic [nbf_pkg::FIFO_CNT_W-1:0]  r_count;
    logic [nbf_pkg::FIFO_PTR_W-1:0]  n_wr_ptr;
    logic [nbf_pkg::FIFO_PTR_W-1:0]  n_rd_ptr;
    logic [nbf_pkg::FIFO_CNT_W-1:0]  n_count;
    logic                            w_pop;

    assign w_pop                = o_res.valid & o_res.ready;
    assign o_res.valid          = (r_count != '0);
    assign o_res.filtered_value = r_mem[r_rd_ptr].value;
    assign o_res.last_of_frame  = r_mem[r_rd_ptr].last;
    assign o_count              = r_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == nbf_pkg::FIFO_PTR_W'(nbf_pkg::FIFO_DEPTH - 1))
                     ? '0 : r_wr_ptr + nbf_pkg::FIFO_PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == nbf_pkg::FIFO_PTR_W'(nbf_pkg::FIFO_DEPTH - 1))
                     ? '0 : r_rd_ptr + nbf_pkg::FIFO_PTR_W'(1);
        end
        if (i_push && !w_pop) begin
            n_count = r_count + nbf_pkg::FIFO_CNT_W'(1);
        end else if (!i_push && w_pop) begin
            n_count = r_count - nbf_pkg::FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

@@ rtl/image_3x3_neighbourhood_filter_top.sv @@
// 3x3 neighbourhood filter top: one item per clock while the result queue has room.
// results lag the stream by one row plus one pixel; the line memory takes one read and one
// write back per clock, so a transfer can follow in every cycle while the 8-entry result
// queue has room; input ready drops once queued plus in-flight items reach 8.
// synchronous active-low reset clears counters, window and queue and loads
// mode 0, width 1024, height 1; line memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "image_3x3_neighbourhood_filter_top_assert.svh"

module image_3x3_neighbourhood_filter_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [nbf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [nbf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    nbf_pix_if.sink                             i_pix,
    nbf_res_if.source                           o_res
);

    logic [nbf_pkg::MODE_W-1:0]   r_mode,    n_mode;
    logic [nbf_pkg::WIDTH_W-1:0]  r_width,   n_width;
    logic [nbf_pkg::HEIGHT_W-1:0] r_height,  n_height;
    logic [nbf_pkg::COL_W-1:0]    r_col,     n_col;
    logic [1:0]                   r_row,     n_row;
    logic [nbf_pkg::COL_W-1:0]    r_res_col, n_res_col;
    logic [nbf_pkg::ROW_W-1:0]    r_res_row, n_res_row;

    logic                         r_s1_v;
    logic                         r_s1_emit;
    nbf_pkg::t_meta               r_s1_meta;

    logic                         w_accept;
    logic [nbf_pkg::PIX_W-1:0]    w_pix;
    logic                         w_col_end;
    logic                         w_emit;
    nbf_pkg::t_meta               w_meta;
    logic [nbf_pkg::WIDTH_W-1:0]  w_cfg_width;
    logic [nbf_pkg::HEIGHT_W-1:0] w_cfg_height;
    logic [nbf_pkg::PIX_W-1:0]    w_col_top;
    logic [nbf_pkg::PIX_W-1:0]    w_col_mid;
    logic [nbf_pkg::PIX_W-1:0]    w_col_bot;
    logic                         w_push;
    nbf_pkg::t_result             w_result;
    logic [1:0]                   w_busy;
    logic [nbf_pkg::FIFO_CNT_W-1:0] w_fifo_count;
    logic [nbf_pkg::FIFO_CNT_W:0]   w_occ;
    logic                         w_pop;

    // every item that might still land in the queue holds a slot
    assign w_occ = {1'b0, w_fifo_count} + (nbf_pkg::FIFO_CNT_W+1)'(r_s1_v)
                 + (nbf_pkg::FIFO_CNT_W+1)'(w_busy);
    assign i_pix.ready = (w_occ < (nbf_pkg::FIFO_CNT_W+1)'(nbf_pkg::FIFO_DEPTH));
    assign w_accept    = i_pix.valid & i_pix.ready;
    assign w_pop       = o_res.valid & o_res.ready;
    assign w_pix       = (i_pix.command == nbf_pkg::CMD_FLUSH) ? '0 : i_pix.pixel_value;

    assign w_col_end = ({1'b0, r_col} + nbf_pkg::WIDTH_W'(1)) >= r_width;
    assign w_emit    = (r_row == 2'd2) || ((r_row == 2'd1) && (r_col != '0));

    // borders of the pixel whose window completes now
    assign w_meta.top    = (r_res_row != '0);
    assign w_meta.bottom = ({1'b0, r_res_row} + nbf_pkg::HEIGHT_W'(1)) < r_height;
    assign w_meta.left   = (r_res_col != '0);
    assign w_meta.right  = ({1'b0, r_res_col} + nbf_pkg::WIDTH_W'(1)) < r_width;
    assign w_meta.last   = !w_meta.bottom && !w_meta.right;

    // zero means one, oversize saturates
    always_comb begin
        w_cfg_width = i_cfg_data[nbf_pkg::WIDTH_W-1:0];
        if (w_cfg_width == '0) begin
            w_cfg_width = nbf_pkg::WIDTH_W'(1);
        end else if (w_cfg_width > nbf_pkg::WIDTH_W'(nbf_pkg::IMAGE_WIDTH_MAX)) begin
            w_cfg_width = nbf_pkg::WIDTH_W'(nbf_pkg::IMAGE_WIDTH_MAX);
        end
        w_cfg_height = i_cfg_data[nbf_pkg::HEIGHT_W-1:0];
        if (w_cfg_height == '0) begin
            w_cfg_height = nbf_pkg::HEIGHT_W'(1);
        end else if (w_cfg_height > nbf_pkg::HEIGHT_W'(nbf_pkg::IMAGE_HEIGHT_MAX)) begin
            w_cfg_height = nbf_pkg::HEIGHT_W'(nbf_pkg::IMAGE_HEIGHT_MAX);
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_width   = r_width;
        n_height  = r_height;
        n_col     = r_col;
        n_row     = r_row;
        n_res_col = r_res_col;
        n_res_row = r_res_row;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                nbf_pkg::CFG_MODE: begin
                    n_mode = i_cfg_data[nbf_pkg::MODE_W-1:0];
                end
                nbf_pkg::CFG_WIDTH: begin
                    n_width   = w_cfg_width;
                    n_col     = '0;
                    n_row     = '0;
                    n_res_col = '0;
                    n_res_row = '0;
                end
                nbf_pkg::CFG_HEIGHT: begin
                    n_height  = w_cfg_height;
                    n_col     = '0;
                    n_row     = '0;
                    n_res_col = '0;
                    n_res_row = '0;
                end
                default: begin
                end
            endcase
        end else if (w_accept) begin
            if (w_col_end) begin
                n_col = '0;
                if (r_row != 2'd2) begin
                    n_row = r_row + 2'd1;
                end
            end else begin
                n_col = r_col + nbf_pkg::COL_W'(1);
            end
            if (w_emit) begin
                if (w_meta.last) begin
                    n_col     = '0;
                    n_row     = '0;
                    n_res_col = '0;
                    n_res_row = '0;
                end else if (w_meta.right) begin
                    n_res_col = r_res_col + nbf_pkg::COL_W'(1);
                end else begin
                    n_res_col = '0;
                    n_res_row = r_res_row + nbf_pkg::ROW_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= nbf_pkg::MODE_BLUR;
            r_width   <= nbf_pkg::WIDTH_W'(nbf_pkg::IMAGE_WIDTH_MAX);
            r_height  <= nbf_pkg::HEIGHT_W'(1);
            r_col     <= '0;
            r_row     <= '0;
            r_res_col <= '0;
            r_res_row <= '0;
            r_s1_v    <= 1'b0;
            r_s1_emit <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_width   <= n_width;
            r_height  <= n_height;
            r_col     <= n_col;
            r_row     <= n_row;
            r_res_col <= n_res_col;
            r_res_row <= n_res_row;
            r_s1_v    <= w_accept;
            r_s1_emit <= w_accept & w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_meta <= w_meta;
        end
    end

    nbf_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_col     (r_col),
        .i_pix     (w_pix),
        .o_col_top (w_col_top),
        .o_col_mid (w_col_mid),
        .o_col_bot (w_col_bot)
    );

    nbf_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_shift   (r_s1_v),
        .i_emit    (r_s1_emit),
        .i_meta    (r_s1_meta),
        .i_mode    (r_mode),
        .i_col_top (w_col_top),
        .i_col_mid (w_col_mid),
        .i_col_bot (w_col_bot),
        .o_valid   (w_push),
        .o_result  (w_result),
        .o_busy    (w_busy)
    );

    nbf_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_result),
        .o_res   (o_res),
        .o_count (w_fifo_count)
    );

    `NBF_ASSERT_SAME(a_fifo_no_overflow, i_clk, i_rst_n, w_push && !w_pop,
        w_fifo_count < nbf_pkg::FIFO_CNT_W'(nbf_pkg::FIFO_DEPTH), "result queue overflow")
    `NBF_ASSERT_NEXT(a_frame_restart, i_clk, i_rst_n,
        w_accept && !i_cfg_we && w_emit && w_meta.last,
        r_col == '0 && r_row == '0 && r_res_col == '0 && r_res_row == '0,
        "counters not cleared after last pixel of frame")
    `NBF_ASSERT_SAME(a_col_in_row, i_clk, i_rst_n, 1'b1,
        (({1'b0, r_col} < r_width) && ({1'b0, r_res_col} < r_width)),
        "column counter beyond image width")
    `NBF_ASSERT_SAME(a_res_row_in_frame, i_clk, i_rst_n, 1'b1,
        ({1'b0, r_res_row} < r_height), "result row beyond image height")

endmodule

`default_nettype wire

@@ sim/tb_image_3x3_neighbourhood_filter_top.sv @@
`timescale 1ns / 1ps
// self-checking bench for image_3x3_neighbourhood_filter_top: predicts every filtered pixel
// from its own copy of line stores, window and counters, checks results in order
// depends on nbf_pkg, nbf_pix_if, nbf_res_if and the filter rtl

module tb_image_3x3_neighbourhood_filter_top;
    import nbf_pkg::*;

    localparam int unsigned LIMIT_CYCLES     = 1_000_000;
    localparam int unsigned DRAIN_CYCLES     = 12;
    localparam int unsigned ROW_CAP          = 4095;
    localparam int unsigned RANDOM_ITEMS     = 300;
    localparam int unsigned MAX_SHOWN        = 10;
    // a full row of the saturated width plus 8 pixels of the next row
    localparam int unsigned SAT_WIDTH_ITEMS  = IMAGE_WIDTH_MAX + 8;
    localparam int unsigned SAT_HEIGHT_ITEMS = 24;

    localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;  // decodes as box blur
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;  // no register behind this index

    typedef struct packed {
        logic             command;
        logic [PIX_W-1:0] value;
    } t_pix_item;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    nbf_pix_if pix_if ();
    nbf_res_if res_if ();

    image_3x3_neighbourhood_filter_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (pix_if),
        .o_res       (res_if)
    );

    t_pix_item pixel_q[$];
    t_result   filtered_q[$];

    // mirror of the filter state and registers
    logic [PIX_W-1:0]    line_above     [IMAGE_WIDTH_MAX];
    logic [PIX_W-1:0]    line_two_above [IMAGE_WIDTH_MAX];
    logic [PIX_W-1:0]    win [9];
    int unsigned         col_cnt;
    int unsigned         row_cnt;
    int unsigned         done_cnt;
    logic [MODE_W-1:0]   mode_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;

    int unsigned bad_count   = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap;
    int unsigned stall_left;
    int unsigned random_items;
    bit          no_idle;
    t_pix_item   next_item;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned frame_width();
        if (width_reg == 0) return 1;
        if (width_reg > IMAGE_WIDTH_MAX) return IMAGE_WIDTH_MAX;
        return width_reg;
    endfunction

    function automatic int unsigned frame_height();
        if (height_reg == 0) return 1;
        if (height_reg > IMAGE_HEIGHT_MAX) return IMAGE_HEIGHT_MAX;
        return height_reg;
    endfunction

    function automatic void restart_frame();
        col_cnt  = 0;
        row_cnt  = 0;
        done_cnt = 0;
    endfunction

    function automatic void reset_mirror();
        for (int k = 0; k < IMAGE_WIDTH_MAX; k++) begin
            line_above[k]     = '0;
            line_two_above[k] = '0;
        end
        for (int k = 0; k < 9; k++) win[k] = '0;
        restart_frame();
        mode_reg   = MODE_BLUR;
        width_reg  = WIDTH_W'(IMAGE_WIDTH_MAX);
        height_reg = HEIGHT_W'(1);
    endfunction

    function automatic void load_reg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_MODE: begin
                mode_reg = data[MODE_W-1:0];
            end
            CFG_WIDTH: begin
                width_reg = data[WIDTH_W-1:0];
                restart_frame();
            end
            CFG_HEIGHT: begin
                height_reg = data[HEIGHT_W-1:0];
                restart_frame();
            end
            default: ;
        endcase
    endfunction

    // taps outside the image are dropped
    function automatic logic [PIX_W-1:0] filter_center(input bit up, input bit down,
                                                      input bit lf, input bit rt);
        bit in_img [9];
        int acc;
        int cnt;
        int nb;
        for (int k = 0; k < 9; k++)
            in_img[k] = !((k < 3 && !up) || (k > 5 && !down) ||
                          (k % 3 == 0 && !lf) || (k % 3 == 2 && !rt));
        if (mode_reg == MODE_LAPLACE || mode_reg == MODE_SHARPEN) begin
            nb = 0;
            for (int k = 1; k < 9; k += 2)
                if (in_img[k]) nb += win[k];
            if (mode_reg == MODE_LAPLACE) acc = nb - 4 * int'(win[4]);
            else acc = 5 * int'(win[4]) - nb;
            if (acc < 0) acc = 0;
            if (acc > 255) acc = 255;
            return acc[PIX_W-1:0];
        end
        acc = 0;
        cnt = 0;
        for (int k = 0; k < 9; k++) begin
            if (in_img[k]) begin
                acc += win[k];
                cnt++;
            end
        end
        acc = acc / cnt;
        return acc[PIX_W-1:0];
    endfunction

    task automatic compute_filtered_pixel(input logic cmd, input logic [PIX_W-1:0] value);
        int unsigned      w;
        int unsigned      h;
        int unsigned      total;
        int unsigned      col;
        int unsigned      q;
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] upper;
        bit               emit;
        t_result          res;
        w     = frame_width();
        h     = frame_height();
        total = w * h;
        pix   = (cmd == CMD_FLUSH) ? '0 : value;
        col   = (col_cnt >= w) ? 0 : col_cnt;
        mid   = line_above[col];
        upper = line_two_above[col];
        line_two_above[col] = mid;
        line_above[col]     = pix;
        for (int k = 0; k < 3; k++) begin
            win[k*3]   = win[k*3+1];
            win[k*3+1] = win[k*3+2];
        end
        win[2] = upper;
        win[5] = mid;
        win[8] = pix;
        emit = (row_cnt >= 2) || (row_cnt == 1 && col >= 1);
        if (col + 1 >= w) begin
            col_cnt = 0;
            if (row_cnt < ROW_CAP) row_cnt++;
        end else begin
            col_cnt = col + 1;
        end
        if (emit && done_cnt < total) begin
            q         = done_cnt;
            res.value = filter_center(q / w >= 1, q / w + 1 < h, q % w >= 1, q % w + 1 < w);
            res.last  = (q + 1 == total);
            filtered_q.push_back(res);
            done_cnt = q + 1;
            if (res.last) restart_frame();
        end
    endtask

    task automatic check_result(input logic [PIX_W-1:0] value, input logic last);
        t_result want;
        if (filtered_q.size() == 0) begin
            if (bad_count < MAX_SHOWN)
                $display("unexpected result: value %0d last %0b", value, last);
            bad_count++;
        end else begin
            want = filtered_q.pop_front();
            if (value !== want.value || last !== want.last) begin
                if (bad_count < MAX_SHOWN)
                    $display("mismatch: expected value %0d last %0b, got value %0d last %0b",
                             want.value, want.last, value, last);
                bad_count++;
            end
        end
    endtask

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pixel_q.size() != 0 || pix_if.valid || filtered_q.size() != 0);
        // items that give no result may still be in the pipeline
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(data);
        load_reg(idx, CFG_DATA_W'(data));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic queue_item(input logic cmd, input logic [PIX_W-1:0] value);
        t_pix_item it;
        it.command = cmd;
        it.value   = value;
        pixel_q.push_back(it);
    endtask

    // one frame plus its flush items, optionally cut short or paused until drained
    task automatic queue_frame(input bit extremes, input bit noisy,
                               input int unsigned stop_at, input int unsigned pause_at);
        int unsigned fw;
        int unsigned n_pix;
        int unsigned n_all;
        logic        cmd;
        logic [PIX_W-1:0] value;
        fw    = frame_width();
        n_pix = fw * frame_height();
        n_all = n_pix + fw + 1;
        for (int unsigned k = 0; k < n_all && k < stop_at; k++) begin
            if (k == pause_at) wait_idle();
            if (k < n_pix) cmd = (noisy && $urandom_range(0, 29) == 0) ? CMD_FLUSH : CMD_PIXEL;
            else cmd = (noisy && $urandom_range(0, 7) == 0) ? CMD_PIXEL : CMD_FLUSH;
            if (extremes && $urandom_range(0, 2) != 0) value = $urandom_range(0, 1) ? '1 : '0;
            else value = PIX_W'($urandom_range(0, 255));
            queue_item(cmd, value);
        end
    endtask

    // sender: one transfer per handshake, random gaps between items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid       <= 1'b0;
            pix_if.command     <= CMD_PIXEL;
            pix_if.pixel_value <= '0;
            send_gap = 0;
        end else begin
            if (pix_if.valid && pix_if.ready)
                compute_filtered_pixel(pix_if.command, pix_if.pixel_value);
            if (!pix_if.valid || pix_if.ready) begin
                if (send_gap != 0) begin
                    pix_if.valid <= 1'b0;
                    send_gap--;
                end else if (pixel_q.size() != 0) begin
                    next_item = pixel_q.pop_front();
                    pix_if.valid       <= 1'b1;
                    pix_if.command     <= next_item.command;
                    pix_if.pixel_value <= next_item.value;
                    send_gap = idle_len();
                end else begin
                    pix_if.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result transfer, stalls at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (res_if.valid && res_if.ready)
                check_result(res_if.filtered_value, res_if.last_of_frame);
            if (stall_left != 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                res_if.ready <= 1'b1;
                stall_left = idle_len();
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int unsigned total;
        int unsigned stop_at;
        int unsigned pause_at;
        int unsigned n_frames;
        bit          extremes;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = CFG_MODE;
        i_cfg_data         = '0;
        no_idle            = 1'b0;
        random_items       = 0;
        reset_mirror();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // 2x2 checkerboard hits both clamps in the kernel modes
        write_reg(CFG_WIDTH, 2);
        write_reg(CFG_HEIGHT, 2);
        for (int m = 0; m < 3; m++) begin
            wait_idle();
            case (m)
                0: write_reg(CFG_MODE, MODE_BLUR);
                1: write_reg(CFG_MODE, MODE_LAPLACE);
                default: write_reg(CFG_MODE, MODE_SHARPEN);
            endcase
            queue_item(CMD_PIXEL, '0);
            queue_item(CMD_PIXEL, '1);
            queue_item(CMD_PIXEL, '1);
            queue_item(CMD_PIXEL, '0);
            repeat (3) queue_item(CMD_FLUSH, '0);
        end

        // zero sizes read as 1x1; flush inside the frame, pixel during flush
        wait_idle();
        write_reg(CFG_WIDTH, 0);
        write_reg(CFG_HEIGHT, 0);
        write_reg(CFG_MODE, MODE_SPARE);
        write_reg(CFG_SPARE, (1 << CFG_DATA_W) - 1);
        queue_item(CMD_FLUSH, 8'hA5);
        queue_item(CMD_PIXEL, 8'h5A);
        queue_item(CMD_FLUSH, 8'h00);

        // sender holds back mid-frame until every result is back
        wait_idle();
        write_reg(CFG_WIDTH, 5);
        write_reg(CFG_HEIGHT, 4);
        write_reg(CFG_MODE, MODE_LAPLACE);
        queue_frame(1'b1, 1'b1, '1, 11);

        // oversized registers saturate to the maxima; frames are cut short,
        // the next size write restarts the stream
        no_idle = 1'b1;
        wait_idle();
        write_reg(CFG_WIDTH, (1 << WIDTH_W) - 1);
        write_reg(CFG_HEIGHT, 2);
        write_reg(CFG_MODE, MODE_SHARPEN);
        queue_frame(1'b0, 1'b0, SAT_WIDTH_ITEMS, '1);
        wait_idle();
        write_reg(CFG_WIDTH, 1);
        write_reg(CFG_HEIGHT, (1 << HEIGHT_W) - 1);
        write_reg(CFG_MODE, MODE_BLUR);
        queue_frame(1'b0, 1'b0, SAT_HEIGHT_ITEMS, '1);

        while (random_items < RANDOM_ITEMS) begin
            wait_idle();
            no_idle = ($urandom_range(0, 3) == 0);
            write_reg(CFG_MODE, $urandom_range(0, 3));
            case ($urandom_range(0, 19))
                18:      write_reg(CFG_WIDTH, 0);
                14, 15, 16, 17: write_reg(CFG_WIDTH, $urandom_range(9, 40));
                19:      write_reg(CFG_WIDTH, $urandom_range(41, 70));
                default: write_reg(CFG_WIDTH, $urandom_range(1, 8));
            endcase
            write_reg(CFG_HEIGHT, $urandom_range(0, 6));
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_SPARE, $urandom_range(0, (1 << CFG_DATA_W) - 1));
            total    = frame_width() * frame_height() + frame_width() + 1;
            n_frames = $urandom_range(1, 3);
            for (int unsigned f = 0; f < n_frames; f++) begin
                extremes = ($urandom_range(0, 3) == 0);
                // an abandoned frame is restarted by the next size write
                if (f == n_frames - 1 && $urandom_range(0, 9) == 0)
                    stop_at = $urandom_range(1, total - 1);
                else
                    stop_at = total;
                if ($urandom_range(0, 11) == 0) pause_at = $urandom_range(1, total - 1);
                else pause_at = total;
                queue_frame(extremes, 1'b1, stop_at, pause_at);
                random_items += stop_at;
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (bad_count == 0 && filtered_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
